@@ rtl/core/centered_fir_filter_defines.svh @@
// assertion macros for the centered fir filter checker
// no dependencies; included by the checker file only
`ifndef CENTERED_FIR_FILTER_DEFINES_SVH
`define CENTERED_FIR_FILTER_DEFINES_SVH

// same-cycle implication, disabled while rst_n is low
`define CFIR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("centered fir filter check failed");

// next-cycle implication, disabled while rst_n is low
`define CFIR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("centered fir filter check failed");

`endif

@@ rtl/core/cfir_pkg.sv @@
// shared constants and types for the centered fir filter
// no dependencies
`timescale 1ns / 1ps

package cfir_pkg;

    localparam int DEF_MAX_TAPS    = 7;
    localparam int DEF_SAMPLE_BITS = 16;

    localparam int NUM_COEFS = 7;
    localparam int COEF_BITS = 16;
    localparam int FRAC_BITS = 15;
    localparam int TAP_BITS  = 3;
    localparam int WARM_BITS = 2;
    localparam int ADDR_BITS = 5;
    localparam int DATA_BITS = 32;

    localparam logic [TAP_BITS-1:0]         TAP_COUNT_RESET = 3'd1;
    localparam logic signed [COEF_BITS-1:0] COEF0_RESET     = 16'sh7FFF;

    // register index, taken from paddr[4:2]
    typedef enum logic [TAP_BITS-1:0] {
        REG_TAP_COUNT = 3'd0,
        REG_COEF_0    = 3'd1,
        REG_COEF_1    = 3'd2,
        REG_COEF_2    = 3'd3,
        REG_COEF_3    = 3'd4,
        REG_COEF_4    = 3'd5,
        REG_COEF_5    = 3'd6,
        REG_COEF_6    = 3'd7
    } t_reg_idx;

endpackage

@@ rtl/core/centered_fir_filter.sv @@
// centered fir filter top level: history, tap products, sum and saturation
// depends on cfir_pkg
`timescale 1ns / 1ps

// Centered FIR filter. One signed sample enters per clock, unless held off, on the
// valid/ready input channel; y[m] = sum of coef_j * x[m - c/2 + j] over the c
// taps in use, with samples outside the signal taken as zero, shifted right by 15
// (floor) and saturated to SAMPLE_BITS. Outputs lag the input by D = (c-1)/2 samples:
// the first D samples of a signal give no output. A sample marked final_sample gives
// its own output (if any) plus the outstanding ones (D, or fewer in a shorter signal),
// the last carrying final_output, and then the history clears for the next signal.
// Throughput is one sample per clock while the output side does not stall; a final
// sample holds the input off while its flushed outputs (up to 3 for 7 taps) are made,
// since the single history register shifts in one zero per cycle when not stalled.
// The output register is loaded through the history, product and sum stages in turn.
// Registers sit on an APB-style port at byte address 4*i: tap_count, then coef_0..6.
// Write configuration only while the filter is idle.
module centered_fir_filter
    import cfir_pkg::*;
#(
    parameter int MAX_TAPS    = DEF_MAX_TAPS,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input sample channel
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic                          i_final_sample,
    // filtered sample channel
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [SAMPLE_BITS-1:0] o_filtered,
    output logic                          o_final_output,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ADDR_BITS-1:0]          paddr,
    input  logic [DATA_BITS-1:0]          pwdata,
    output logic [DATA_BITS-1:0]          prdata,
    output logic                          pready
);

    localparam int PROD_W = COEF_BITS + SAMPLE_BITS;
    localparam int ACC_W  = PROD_W + $clog2(MAX_TAPS + 1);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [TAP_BITS-1:0]         r_tap_count;
    logic signed [COEF_BITS-1:0] r_coef [NUM_COEFS];
    logic                        cfg_wr;
    t_reg_idx                    cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = t_reg_idx'(paddr[ADDR_BITS-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_count <= TAP_COUNT_RESET;
            for (int k = 0; k < NUM_COEFS; k++) begin
                r_coef[k] <= '0;
            end
            r_coef[0] <= COEF0_RESET;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_TAP_COUNT: r_tap_count <= pwdata[TAP_BITS-1:0];
                REG_COEF_0:    r_coef[0]   <= pwdata[COEF_BITS-1:0];
                REG_COEF_1:    r_coef[1]   <= pwdata[COEF_BITS-1:0];
                REG_COEF_2:    r_coef[2]   <= pwdata[COEF_BITS-1:0];
                REG_COEF_3:    r_coef[3]   <= pwdata[COEF_BITS-1:0];
                REG_COEF_4:    r_coef[4]   <= pwdata[COEF_BITS-1:0];
                REG_COEF_5:    r_coef[5]   <= pwdata[COEF_BITS-1:0];
                REG_COEF_6:    r_coef[6]   <= pwdata[COEF_BITS-1:0];
                default: ;
            endcase
        end
    end

    // register readback, coefficients sign-extended
    always_comb begin
        case (cfg_idx)
            REG_TAP_COUNT: prdata = DATA_BITS'(r_tap_count);
            REG_COEF_0:    prdata = DATA_BITS'(r_coef[0]);
            REG_COEF_1:    prdata = DATA_BITS'(r_coef[1]);
            REG_COEF_2:    prdata = DATA_BITS'(r_coef[2]);
            REG_COEF_3:    prdata = DATA_BITS'(r_coef[3]);
            REG_COEF_4:    prdata = DATA_BITS'(r_coef[4]);
            REG_COEF_5:    prdata = DATA_BITS'(r_coef[5]);
            REG_COEF_6:    prdata = DATA_BITS'(r_coef[6]);
            default:       prdata = '0;
        endcase
    end

    // taps in use: zero acts as one, large counts clamp to MAX_TAPS
    logic [TAP_BITS-1:0]  taps_c;
    logic [WARM_BITS-1:0] delay_d;

    always_comb begin
        if (r_tap_count == '0) begin
            taps_c = TAP_BITS'(1);
        end else if (r_tap_count > TAP_BITS'(MAX_TAPS)) begin
            taps_c = TAP_BITS'(MAX_TAPS);
        end else begin
            taps_c = r_tap_count;
        end
    end

    // output lag in samples, (c-1)/2
    assign delay_d = WARM_BITS'((taps_c - 1'b1) >> 1);

    // ------------------------------------------------------------------
    // stage handshakes, each stage loads when empty or draining
    // ------------------------------------------------------------------
    logic r_tok_valid, r_tok_last;
    logic r_s1_valid, r_s1_last;
    logic r_out_valid;
    logic out_free, s1_move, s1_free, tok_move, tok_free;
    logic in_accept, flush_gen, hist_clear;
    logic [WARM_BITS-1:0] r_flush_left;

    assign out_free  = !r_out_valid || i_ready;
    assign s1_move   = r_s1_valid && out_free;
    assign s1_free   = !r_s1_valid || out_free;
    assign tok_move  = r_tok_valid && s1_free;
    assign tok_free  = !r_tok_valid || tok_move;
    // no new sample while zeros are still being shifted in for a flush
    assign o_ready   = tok_free && (r_flush_left == '0);
    assign in_accept = i_valid && o_ready;
    assign flush_gen = tok_free && (r_flush_left != '0);
    // history empties once the last evaluation of a signal has been taken
    assign hist_clear = tok_move && r_tok_last;

    // ------------------------------------------------------------------
    // stage 0: sample history and the pending evaluation token
    // ------------------------------------------------------------------
    logic signed [SAMPLE_BITS-1:0] r_hist [MAX_TAPS];
    logic signed [SAMPLE_BITS-1:0] n_hist [MAX_TAPS];
    logic signed [SAMPLE_BITS-1:0] hist_base [MAX_TAPS];
    logic [WARM_BITS-1:0]          r_warm, n_warm, n_flush_left, flushes;
    logic                          n_tok_valid, n_tok_last, emit;

    assign emit    = (r_warm >= delay_d);
    assign flushes = !i_final_sample ? '0 :
                     (emit ? delay_d : WARM_BITS'(r_warm + 1'b1));

    always_comb begin
        n_warm       = r_warm;
        n_flush_left = r_flush_left;
        n_tok_valid  = r_tok_valid;
        n_tok_last   = r_tok_last;
        for (int k = 0; k < MAX_TAPS; k++) begin
            hist_base[k] = hist_clear ? '0 : r_hist[k];
        end
        n_hist = hist_base;

        if (tok_move) begin
            n_tok_valid = 1'b0;
        end

        if (in_accept) begin
            // push the new sample, newest at entry 0
            n_hist[0] = i_sample;
            for (int k = 1; k < MAX_TAPS; k++) begin
                n_hist[k] = hist_base[k-1];
            end
            n_tok_valid  = emit;
            n_tok_last   = i_final_sample && (flushes == '0);
            n_flush_left = flushes;
            if (i_final_sample) begin
                n_warm = '0;
            end else if (r_warm != '1) begin
                n_warm = r_warm + 1'b1;
            end
        end else if (flush_gen) begin
            // flush step: shift in a zero and evaluate again
            n_hist[0] = '0;
            for (int k = 1; k < MAX_TAPS; k++) begin
                n_hist[k] = hist_base[k-1];
            end
            n_tok_valid  = 1'b1;
            n_tok_last   = (r_flush_left == WARM_BITS'(1));
            n_flush_left = r_flush_left - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_TAPS; k++) begin
                r_hist[k] <= '0;
            end
            r_warm       <= '0;
            r_flush_left <= '0;
            r_tok_valid  <= 1'b0;
        end else begin
            r_hist       <= n_hist;
            r_warm       <= n_warm;
            r_flush_left <= n_flush_left;
            r_tok_valid  <= n_tok_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tok_last <= n_tok_last;
    end

    // ------------------------------------------------------------------
    // stage 1: tap products, h[j] * hist[c-1-j] for j < c
    // ------------------------------------------------------------------
    logic signed [SAMPLE_BITS-1:0] s1_tap [MAX_TAPS];
    logic signed [PROD_W-1:0]      n_prod [MAX_TAPS];
    logic signed [PROD_W-1:0]      r_prod [MAX_TAPS];

    always_comb begin
        for (int j = 0; j < MAX_TAPS; j++) begin
            s1_tap[j] = '0;
            for (int k = 0; k < MAX_TAPS; k++) begin
                if ((TAP_BITS + 1)'(j + k + 1) == {1'b0, taps_c}) begin
                    s1_tap[j] = r_hist[k];
                end
            end
            n_prod[j] = PROD_W'(r_coef[j]) * PROD_W'(s1_tap[j]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (tok_move) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tok_move) begin
            r_prod    <= n_prod;
            r_s1_last <= r_tok_last;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: sum, floor shift by 15, saturate into the output register
    // ------------------------------------------------------------------
    logic signed [ACC_W-1:0]       acc, acc_q;
    logic signed [SAMPLE_BITS-1:0] sat_val;
    logic                          ovf;
    logic signed [SAMPLE_BITS-1:0] r_out_data;
    logic                          r_out_last;

    always_comb begin
        acc = '0;
        for (int j = 0; j < MAX_TAPS; j++) begin
            acc = acc + ACC_W'(r_prod[j]);
        end
        acc_q = acc >>> FRAC_BITS;
        // out of range when the result sign and the bits above it disagree
        ovf = (acc_q[ACC_W-1:SAMPLE_BITS-1] != '0) && (acc_q[ACC_W-1:SAMPLE_BITS-1] != '1);
        if (!ovf) begin
            sat_val = acc_q[SAMPLE_BITS-1:0];
        end else if (acc_q[ACC_W-1]) begin
            sat_val = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
        end else begin
            sat_val = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_data <= sat_val;
            r_out_last <= r_s1_last;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_filtered     = r_out_data;
    assign o_final_output = r_out_last;

endmodule

@@ rtl/core/cfir_checker.sv @@
// port-level checks for the centered fir filter, bound to the top level
// depends on cfir_pkg and centered_fir_filter_defines.svh
`timescale 1ns / 1ps
`include "centered_fir_filter_defines.svh"

module cfir_checker
    import cfir_pkg::*;
#(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_valid,
    input logic                   i_ready,
    input logic [SAMPLE_BITS-1:0] o_filtered,
    input logic                   o_final_output,
    input logic                   psel,
    input logic                   penable,
    input logic                   pwrite,
    input logic [ADDR_BITS-1:0]   paddr,
    input logic [DATA_BITS-1:0]   pwdata,
    input logic [DATA_BITS-1:0]   prdata
);

    // a stalled result keeps its value and its final mark
    `CFIR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_filtered) && $stable(o_final_output))

    // reset empties the output register
    `CFIR_ASSERT_NEXT(a_reset_empty, i_clk, 1'b1, !i_rst_n, !o_valid)

    // a written register reads back its low three bits at the same address
    `CFIR_ASSERT_NEXT(a_cfg_readback, i_clk, i_rst_n, psel && penable && pwrite, (paddr != $past(paddr)) || (prdata[2:0] == $past(pwdata[2:0])))

endmodule

bind centered_fir_filter cfir_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_cfir_checker (.*);

@@ sim/tb_top.sv @@
// self-checking testbench for centered_fir_filter: random and directed sample streams
// depends on cfir_pkg and the centered_fir_filter rtl; holds its own filter model
`timescale 1ns / 1ps

module tb_top;
    import cfir_pkg::*;

    localparam int SW            = DEF_SAMPLE_BITS;
    localparam int TOTAL_ITEMS   = 410;
    localparam int IDLE_PCT      = 29;
    localparam int SETTLE_CYCLES = 8;     // pipeline is three deep, leave some slack
    localparam int HOLD_CYCLES   = 150;   // long receiver back-pressure stretch
    localparam int STALL_LIMIT   = 2000;  // cycles with no transaction on either side
    localparam int SHOWN_ERRORS  = 10;

    typedef logic signed [SW-1:0]        sample_t;
    typedef logic signed [COEF_BITS-1:0] coef_t;
    typedef coef_t                       coef_set_t [NUM_COEFS];

    // one filtered output as the filter should give it
    typedef struct {
        sample_t value;
        logic    last;
    } filt_result_t;

    // ------------------------------------------------------------------
    // scoreboard: a bit-true copy of the filter, fed with every accepted
    // input transaction, and a queue of outputs still to come
    // ------------------------------------------------------------------
    class fir_scoreboard;
        logic [TAP_BITS-1:0] taps;
        coef_t               coefs [NUM_COEFS];
        sample_t             history [NUM_COEFS];   // entry 0 is the newest sample
        int                  warm;                  // samples of this signal, stops at 3
        filt_result_t        filtered_due [$];
        int                  fail_count;

        function new();
            taps = TAP_COUNT_RESET;
            foreach (coefs[k]) coefs[k] = '0;
            coefs[0] = COEF0_RESET;
            clear_signal();
            fail_count = 0;
        endfunction

        function void clear_signal();
            foreach (history[k]) history[k] = '0;
            warm = 0;
        endfunction

        function void write_reg(t_reg_idx idx, logic [DATA_BITS-1:0] v);
            if (idx == REG_TAP_COUNT) begin
                taps = v[TAP_BITS-1:0];
            end else begin
                coefs[int'(idx) - int'(REG_COEF_0)] = v[COEF_BITS-1:0];
            end
        endfunction

        function void shift_in(sample_t s);
            for (int k = NUM_COEFS - 1; k > 0; k--) history[k] = history[k-1];
            history[0] = s;
        endfunction

        // append one expected output at the back of the queue
        function void add_due(filt_result_t r);
            filtered_due.insert(filtered_due.size(), r);
        endfunction

        // exact sum of products, floor shift by the fraction bits, saturate
        function sample_t tap_sum(int c);
            longint acc;
            longint q;
            longint hi;
            acc = 0;
            hi  = (longint'(1) <<< (SW - 1)) - 1;
            for (int j = 0; j < c; j++) acc += longint'(coefs[j]) * longint'(history[c-1-j]);
            q = acc >>> FRAC_BITS;
            if (q > hi) q = hi;
            if (q < -hi - 1) q = -hi - 1;
            return sample_t'(q);
        endfunction

        function void note_sample(sample_t s, logic fin);
            int c;
            int lag;
            int prior;
            int total;
            int made;
            filt_result_t r;
            c     = (taps == 0) ? 1 : int'(taps);
            lag   = c - 1 - c / 2;
            prior = warm;
            total = (prior >= lag) ? 1 : 0;
            if (fin) total += (prior >= lag) ? lag : prior + 1;
            made  = 0;
            shift_in(s);
            if (warm < 3) warm++;
            if (prior >= lag) begin
                r.value = tap_sum(c);
                r.last  = fin && (made == total - 1);
                add_due(r);
                made++;
            end
            if (fin) begin
                // flush the outstanding outputs with zeros behind the signal
                while (made < total) begin
                    shift_in('0);
                    r.value = tap_sum(c);
                    r.last  = (made == total - 1);
                    add_due(r);
                    made++;
                end
                clear_signal();
            end
        endfunction

        function void check_filtered(sample_t got, logic got_last);
            filt_result_t want;
            if (filtered_due.size() == 0) begin
                fail_count++;
                if (fail_count <= SHOWN_ERRORS)
                    $display("error: unexpected output filtered=%0d final=%0b", got, got_last);
                return;
            end
            want = filtered_due.pop_front();
            if (got !== want.value || got_last !== want.last) begin
                fail_count++;
                if (fail_count <= SHOWN_ERRORS)
                    $display("error: filtered expected %0d final %0b, got %0d final %0b",
                             want.value, want.last, got, got_last);
            end
        endfunction

        function int pending();
            return filtered_due.size();
        endfunction
    endclass

    // ------------------------------------------------------------------
    // clock, reset and block signals; every input starts at a known value
    // ------------------------------------------------------------------
    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 i_valid        = 1'b0;
    logic                 o_ready;
    sample_t              i_sample       = '0;
    logic                 i_final_sample = 1'b0;
    logic                 o_valid;
    logic                 i_ready        = 1'b0;
    sample_t              o_filtered;
    logic                 o_final_output;
    logic                 psel           = 1'b0;
    logic                 penable        = 1'b0;
    logic                 pwrite         = 1'b0;
    logic [ADDR_BITS-1:0] paddr          = '0;
    logic [DATA_BITS-1:0] pwdata         = '0;
    logic [DATA_BITS-1:0] prdata;
    logic                 pready;

    // test control, set by the stimulus process
    logic quiet       = 1'b0;   // no idling on either side while high
    logic rx_hold_req = 1'b0;   // ask the receiver for a long back-pressure stretch
    int   items_sent  = 0;
    int   stall_cycles = 0;

    fir_scoreboard sb = new();

    always #5 i_clk = ~i_clk;

    centered_fir_filter dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_sample       (i_sample),
        .i_final_sample (i_final_sample),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_filtered     (o_filtered),
        .o_final_output (o_final_output),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // ------------------------------------------------------------------
    // output side: check every output transaction at the rising edge
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) sb.check_filtered(o_filtered, o_final_output);
    end

    // receiver: random stalls, a quiet stretch, and one long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req) begin
                hold_left = HOLD_CYCLES;
                rx_hold_req <= 1'b0;
            end
            if (hold_left > 0) begin
                i_ready = 1'b0;
                hold_left--;
            end else begin
                i_ready = quiet || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // watchdog: ends the run if neither channel moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("centered_fir_filter: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // driver tasks; all of them start and end just after a falling edge
    // ------------------------------------------------------------------

    // offer one sample, with random idle cycles ahead of it, and hold it
    // until the input transaction completes
    task automatic send_sample(sample_t s, logic fin);
        while (!quiet && $urandom_range(99) < IDLE_PCT) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid        = 1'b1;
        i_sample       = s;
        i_final_sample = fin;
        do @(posedge i_clk); while (!o_ready);
        sb.note_sample(s, fin);
        items_sent++;
        @(negedge i_clk);
    endtask

    // stop offering and wait until every expected output has come out,
    // then give the pipeline time to finish work that yields no output
    task automatic drain_outputs();
        i_valid = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // setup cycle then access cycle; the register is written at the edge
    // where psel, penable, pwrite and pready are all high
    task automatic apb_write(t_reg_idx idx, logic [DATA_BITS-1:0] v);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = ADDR_BITS'({idx, 2'b00});
        pwdata  = v;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.write_reg(idx, v);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // all registers are rewritten each time, only while the filter is idle
    task automatic program_filter(logic [TAP_BITS-1:0] taps, coef_set_t h);
        drain_outputs();
        apb_write(REG_TAP_COUNT, DATA_BITS'(taps));
        for (int k = 0; k < NUM_COEFS; k++)
            apb_write(t_reg_idx'(int'(REG_COEF_0) + k), {{(DATA_BITS-COEF_BITS){h[k][COEF_BITS-1]}}, h[k]});
    endtask

    function automatic sample_t rand_sample();
        case ($urandom_range(9))
            0:       return sample_t'(2 ** (SW - 1) - 1);
            1:       return sample_t'(-(2 ** (SW - 1)));
            2, 3:    return sample_t'(int'($urandom_range(64)) - 32);
            default: return sample_t'($urandom());
        endcase
    endfunction

    function automatic coef_t rand_coef();
        case ($urandom_range(9))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2, 3, 4: return coef_t'(int'($urandom_range(8192)) - 4096);
            default: return coef_t'($urandom());
        endcase
    endfunction

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial begin
        coef_set_t h;
        int        phase;
        int        left;
        int        len;
        logic      paused;

        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // reset settings, one tap of 0x7FFF, scale samples by nearly one: extremes and zero
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh0000, 1'b1);

        // seven full-scale taps: positive saturation and the longest lag
        h = '{default: 16'sh7FFF};
        program_filter(3'd7, h);
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh7FFF, 1'b1);
        // signals shorter than the lag: final sample still during warmup
        send_sample(16'sh8000, 1'b1);
        send_sample(16'sd100, 1'b0);
        send_sample(-16'sd200, 1'b1);

        // zero tap count acts as one tap; most negative squared saturates
        h = '{default: 16'sh0000};
        h[0] = 16'sh8000;
        program_filter(3'd0, h);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sd5, 1'b0);
        send_sample(-16'sd5, 1'b1);

        // even tap count, signal left open across a tap count change
        h = '{16'sh8000, 16'sh7FFF, 16'sd1, -16'sd1, 16'sd0, 16'sd0, 16'sd0};
        program_filter(3'd4, h);
        send_sample(16'sd1000, 1'b0);
        send_sample(-16'sd1, 1'b0);
        send_sample(16'sd7, 1'b0);
        h = '{16'sh8000, 16'sd12345, -16'sd7, 16'sd3, 16'sh7FFF, -16'sd1, 16'sd16384};
        program_filter(3'd7, h);
        send_sample(16'sd2, 1'b0);
        send_sample(-16'sd3, 1'b0);
        send_sample(16'sd4, 1'b1);

        // random phases: new settings, then whole signals of random content;
        // a phase may end inside a signal, which then runs on under new settings
        phase = 0;
        while (items_sent < TOTAL_ITEMS) begin
            foreach (h[k]) h[k] = rand_coef();
            program_filter(TAP_BITS'($urandom_range(7)), h);
            quiet <= (phase == 1);
            if (phase == 3) rx_hold_req <= 1'b1;
            paused = 1'b0;
            left   = $urandom_range(25, 50);
            while (left > 0 && items_sent < TOTAL_ITEMS) begin
                len = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
                for (int k = 0; k < len && left > 0; k++) begin
                    send_sample(rand_sample(), k == len - 1);
                    left--;
                end
                // sender waits once for the output side to catch up
                if (phase == 5 && !paused) begin
                    drain_outputs();
                    paused = 1'b1;
                end
            end
            phase++;
        end

        drain_outputs();
        if (sb.fail_count == 0) begin
            $display("centered_fir_filter: match");
        end else begin
            $display("centered_fir_filter: mismatch");
        end
        $finish;
    end

endmodule
